FILE: rtl/bbr_pkg.sv
// shared constants and types for the bit range blit with raster ops
package bbr_pkg;

  localparam int WORD_BITS_DEF = 32;

  localparam int OFFSET_W = 5;
  localparam int COUNT_W  = 16;
  localparam int ROP_W    = 3;
  localparam int LEFT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_OP  = 2'd3;

  // raster op codes
  localparam logic [ROP_W-1:0] ROP_COPY   = 3'd0;
  localparam logic [ROP_W-1:0] ROP_INVERT = 3'd1;
  localparam logic [ROP_W-1:0] ROP_AND    = 3'd2;
  localparam logic [ROP_W-1:0] ROP_OR     = 3'd3;
  localparam logic [ROP_W-1:0] ROP_XOR    = 3'd4;

  typedef struct packed {
    logic [OFFSET_W-1:0] src_offset;
    logic [OFFSET_W-1:0] dst_offset;
    logic [ROP_W-1:0]    raster_op;
  } blit_cfg_t;

endpackage

FILE: rtl/bbr_word_op.sv
// one destination word: funnel shift, head/tail mask and raster op
module bbr_word_op import bbr_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  blit_cfg_t                       cfg,
  input  logic [LEFT_W-1:0]               bits_left,
  input  logic                            at_first_word,
  input  logic [WORD_BITS-1:0]            old_dst_word,
  input  logic [WORD_BITS-1:0]            src_low_word,
  input  logic [WORD_BITS-1:0]            src_high_word,
  output logic [WORD_BITS-1:0]            new_dst_word,
  output logic [$clog2(WORD_BITS+1)-1:0]  take_bits
);

  localparam int OFF_W = $clog2(WORD_BITS);
  localparam int N_W   = $clog2(WORD_BITS + 1);
  localparam logic [7:0] W8 = 8'(WORD_BITS);

  logic [7:0]           s_red, d_red, diff;
  logic [OFF_W-1:0]     s_off, d_off, shift, off;
  logic [N_W-1:0]       room, n;
  logic [2*WORD_BITS-1:0] pair;
  logic [WORD_BITS-1:0] bits, mask, res;

  // offsets modulo the word size, a few narrow subtract steps
  always_comb begin
    s_red = 8'(cfg.src_offset);
    d_red = 8'(cfg.dst_offset);
    for (int i = 0; i < 4; i++) begin
      if (s_red >= W8) s_red = s_red - W8;
      if (d_red >= W8) d_red = d_red - W8;
    end
  end

  assign s_off = s_red[OFF_W-1:0];
  assign d_off = d_red[OFF_W-1:0];

  always_comb begin
    diff = 8'(s_off) + W8 - 8'(d_off);
    if (diff >= W8) diff = diff - W8;
  end
  assign shift = diff[OFF_W-1:0];

  assign pair = {src_high_word, src_low_word} >> shift;
  assign bits = pair[WORD_BITS-1:0];

  assign off  = at_first_word ? d_off : '0;
  assign room = N_W'(WORD_BITS) - N_W'(off);
  assign n    = (bits_left < LEFT_W'(room)) ? bits_left[N_W-1:0] : room;
  // low n ones placed at the current offset
  assign mask = ({WORD_BITS{1'b1}} >> (N_W'(WORD_BITS) - n)) << off;

  always_comb begin
    case (cfg.raster_op)
      ROP_COPY:   res = bits;
      ROP_INVERT: res = ~bits;
      ROP_AND:    res = bits & old_dst_word;
      ROP_OR:     res = bits | old_dst_word;
      ROP_XOR:    res = bits ^ old_dst_word;
      default:    res = old_dst_word;
    endcase
  end

  assign new_dst_word = (old_dst_word & ~mask) | (res & mask);
  assign take_bits    = n;

endmodule

FILE: rtl/bit_range_blit_rop.sv
// bit range blit top level: config registers, run tracking and item pipeline
// an accepted item waits in the input register, then the word op result goes into the result register
// throughput: one item per cycle through the single combinational word op, while m_tready is not held low
// output register decouples sides; a new item is taken into an empty input register while a result waits
// reset (rst, synchronous): config to defaults, run restarted, pipeline empty
// any config write restarts the run, from the run length being written or else the run length register
module bit_range_blit_rop import bbr_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // old_dst_word, src_low_word, src_high_word
  input  logic [((3*WORD_BITS+7)/8)*8-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // new_dst_word
  output logic [((WORD_BITS+7)/8)*8-1:0]         m_tdata,
  output logic                                   m_tlast
);

  localparam int N_W   = $clog2(WORD_BITS + 1);
  localparam int OUT_W = ((WORD_BITS + 7) / 8) * 8;

  blit_cfg_t            cfg;
  logic [COUNT_W-1:0]   run_length;
  logic [LEFT_W-1:0]    bits_left, bits_left_next;
  logic                 at_first_word;

  logic                 in_valid;
  logic [WORD_BITS-1:0] in_dst, in_lo, in_hi;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_word;
  logic                 out_last;

  logic                 advance;
  logic [WORD_BITS-1:0] word_res;
  logic [N_W-1:0]       take_bits;
  logic                 run_done;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  bbr_word_op #(.WORD_BITS(WORD_BITS)) u_word_op (
    .cfg           (cfg),
    .bits_left     (bits_left),
    .at_first_word (at_first_word),
    .old_dst_word  (in_dst),
    .src_low_word  (in_lo),
    .src_high_word (in_hi),
    .new_dst_word  (word_res),
    .take_bits     (take_bits)
  );

  assign bits_left_next = bits_left - LEFT_W'(take_bits);
  assign run_done       = (bits_left_next == '0);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_offset <= '0;
      cfg.dst_offset <= '0;
      cfg.raster_op  <= ROP_COPY;
      run_length     <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_OFFSET: cfg.src_offset <= cfg_data[OFFSET_W-1:0];
        REG_DST_OFFSET: cfg.dst_offset <= cfg_data[OFFSET_W-1:0];
        REG_BIT_COUNT:  run_length     <= cfg_data[COUNT_W-1:0];
        REG_RASTER_OP:  cfg.raster_op  <= cfg_data[ROP_W-1:0];
        default:        ;
      endcase
    end
  end

  // run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left     <= LEFT_W'(1);
      at_first_word <= 1'b1;
    end else if (cfg_we) begin
      // restart with the value being written when it is the run length
      bits_left     <= (cfg_index == REG_BIT_COUNT) ? LEFT_W'(cfg_data[COUNT_W-1:0])
                                                    : LEFT_W'(run_length);
      at_first_word <= 1'b1;
    end else if (advance) begin
      if (run_done) begin
        bits_left     <= LEFT_W'(run_length);
        at_first_word <= 1'b1;
      end else begin
        bits_left     <= bits_left_next;
        at_first_word <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_dst <= s_tdata[WORD_BITS-1:0];
      in_lo  <= s_tdata[2*WORD_BITS-1:WORD_BITS];
      in_hi  <= s_tdata[3*WORD_BITS-1:2*WORD_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word_res;
      out_last <= run_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_word);
  assign m_tlast  = out_last;

endmodule

FILE: sim/bbr_checker.sv
`timescale 1ns / 1ps
// scoreboard for the bit range blit: predicts each destination word and checks the results
module bbr_checker import bbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // old_dst_word, src_low_word, src_high_word
  input  logic [95:0]           s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // new_dst_word
  input  logic [31:0]           m_tdata,
  input  logic                  m_tlast,
  output int                    pending,
  output int                    fail_count
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } blit_result_t;

  blit_result_t expected_words[$];
  blit_result_t want;

  // shadow of the block's registers and run state
  logic [OFFSET_W-1:0] src_off;
  logic [OFFSET_W-1:0] dst_off;
  logic [COUNT_W-1:0]  run_len;
  logic [ROP_W-1:0]    rop;
  logic [LEFT_W-1:0]   bits_left;
  logic                first_word;
  int                  fails = 0;

  function automatic blit_result_t raster_blit(input logic [31:0] dst, input logic [31:0] lo,
                                               input logic [31:0] hi);
    int           off;
    int           room;
    int           n;
    int           shift;
    logic [63:0]  ones;
    logic [63:0]  pair;
    logic [31:0]  mask;
    logic [31:0]  bits;
    logic [31:0]  res;
    blit_result_t r;
    off   = first_word ? int'(dst_off) : 0;
    room  = 32 - off;
    n     = (int'(bits_left) < room) ? int'(bits_left) : room;
    ones  = (64'd1 << n) - 64'd1;
    mask  = ones[31:0] << off;
    // funnel shift of the source pair by the offset difference
    shift = (int'(src_off) + 32 - int'(dst_off)) % 32;
    pair  = {hi, lo} >> shift;
    bits  = pair[31:0];
    case (rop)
      ROP_COPY:   res = bits;
      ROP_INVERT: res = ~bits;
      ROP_AND:    res = bits & dst;
      ROP_OR:     res = bits | dst;
      ROP_XOR:    res = bits ^ dst;
      default:    res = dst;
    endcase
    r.word     = (dst & ~mask) | (res & mask);
    bits_left  = bits_left - LEFT_W'(n);
    first_word = 1'b0;
    r.last     = (bits_left == '0);
    if (r.last) begin
      bits_left  = {1'b0, run_len};
      first_word = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      src_off    = '0;
      dst_off    = '0;
      run_len    = COUNT_W'(1);
      rop        = ROP_COPY;
      bits_left  = LEFT_W'(1);
      first_word = 1'b1;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_OFFSET: src_off = cfg_data[OFFSET_W-1:0];
          REG_DST_OFFSET: dst_off = cfg_data[OFFSET_W-1:0];
          REG_BIT_COUNT:  run_len = cfg_data[COUNT_W-1:0];
          REG_RASTER_OP:  rop     = cfg_data[ROP_W-1:0];
          default: ;
        endcase
        bits_left  = {1'b0, run_len};
        first_word = 1'b1;
      end
      if (s_tvalid && s_tready)
        expected_words.push_back(raster_blit(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]));
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected item: new_dst_word %h run_last %b", m_tdata, m_tlast);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (m_tdata !== want.word) begin
            $error("new_dst_word: expected %h, actual %h", want.word, m_tdata);
            fails++;
          end
          if (m_tlast !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, m_tlast);
            fails++;
          end
        end
      end
      pending <= expected_words.size();
    end
    fail_count <= fails;
  end

endmodule

FILE: sim/tb_bit_range_blit_rop.sv
`timescale 1ns / 1ps
// testbench top for the bit range blit: stimulus, flow control and verdict
module tb_bit_range_blit_rop;
  import bbr_pkg::*;

  localparam logic [ROP_W-1:0] ROP_UNKNOWN = 3'd7;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // old_dst_word, src_low_word, src_high_word
  logic [95:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // new_dst_word
  logic [31:0]           m_tdata;
  logic                  m_tlast;

  int pending;
  int fail_count;
  int items_sent = 0;
  int cycles = 0;
  logic calm;

  logic [CFG_IDX_W-1:0]  reg_codes [4] = '{REG_SRC_OFFSET, REG_DST_OFFSET, REG_BIT_COUNT,
                                           REG_RASTER_OP};
  logic [CFG_DATA_W-1:0] cfg_shadow [4] = '{16'd0, 16'd0, 16'd1, 16'd0};

  always #5 clk = ~clk;

  bit_range_blit_rop u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  bbr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // a stretch in the middle of the run with no idling on either side
  assign calm = (items_sent >= 900) && (items_sent < 1300);

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [95:0] item);
    if (!calm && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // block goes idle: every expected word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] which, input logic [CFG_DATA_W-1:0] src,
                           input logic [CFG_DATA_W-1:0] dst, input logic [CFG_DATA_W-1:0] cnt,
                           input logic [CFG_DATA_W-1:0] op, input int words);
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{src, dst, cnt, op};
    for (int i = 0; i < 4; i++) begin
      if (which[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= reg_codes[i];
        cfg_data  <= vals[i];
        cfg_shadow[i] = vals[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    for (int i = 0; i < words; i++)
      send_item({corner_word(), corner_word(), corner_word()});
    drain();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'($urandom_range(0, 65535));
      1:       return 16'd0;
      2:       return 16'd31;
      default: return CFG_DATA_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 16'd0;
    if (r < 8)  return CFG_DATA_W'($urandom_range(1000, 65535));
    if (r < 10) return 16'd65535;
    if (r < 13) return 16'd1;
    return CFG_DATA_W'($urandom_range(1, 200));
  endfunction

  initial begin
    int target;
    int run_words;
    int words;
    logic [3:0] which;
    logic first_pass;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, field extremes, every op, short and empty runs
    send_item('0);
    send_item('1);
    drain();
    run_phase(4'b1111, 16'd31, 16'd0,  16'd40,    16'(ROP_INVERT),  2);
    run_phase(4'b1111, 16'd0,  16'd31, 16'd3,     16'(ROP_AND),     2);
    run_phase(4'b1100, 16'd0,  16'd0,  16'd0,     16'(ROP_OR),      2);
    run_phase(4'b1111, 16'd5,  16'd17, 16'd70,    16'(ROP_UNKNOWN), 3);
    run_phase(4'b1111, 16'd31, 16'd31, 16'd65535, 16'(ROP_XOR),     3);
    run_phase(4'b1111, 16'd0,  16'd20, 16'd10,    16'(ROP_COPY),    2);
    run_phase(4'b0011, 16'd12, 16'd3,  16'd10,    16'(ROP_COPY),    2);

    // random phases: new settings, then words for one to three runs plus up to two more, at most 48
    target = items_sent + RANDOM_ITEMS;
    first_pass = 1'b1;
    while (items_sent < target) begin
      which = first_pass ? 4'b1111 : 4'($urandom_range(1, 15));
      first_pass = 1'b0;
      for (int i = 0; i < 4; i++)
        if (which[i]) begin
          case (i)
            0, 1:    cfg_shadow[i] = pick_offset();
            2:       cfg_shadow[i] = pick_count();
            default: cfg_shadow[i] = ($urandom_range(0, 9) == 0) ?
                                     CFG_DATA_W'($urandom_range(5, 7)) :
                                     CFG_DATA_W'($urandom_range(0, 4));
          endcase
        end
      run_words = (cfg_shadow[2] == 0) ? 1 :
                  (int'(cfg_shadow[1][OFFSET_W-1:0]) + int'(cfg_shadow[2]) + 31) / 32;
      words = run_words * $urandom_range(1, 3) + $urandom_range(0, 2);
      if (words > 48) words = 48;
      run_phase(which, cfg_shadow[0], cfg_shadow[1], cfg_shadow[2], cfg_shadow[3], words);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
